[design/rhss_pkg.sv]
// Shared constants, types and arithmetic helpers for the rolling hash substring search block.
package rhss_pkg;

	// Pattern store and window depth.
	localparam int MAX_PATTERN = 64;
	localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int LEN_W       = $clog2(MAX_PATTERN + 1);

	localparam int CFG_W  = 7;
	localparam int BYTE_W = 8;
	localparam int POS_W  = 32;
	localparam int HASH_W = 7;

	// Hash modulus; the base of 256 is the byte concatenation itself.
	localparam int HASH_MOD = 101;

	// Reciprocal for x mod 101, exact for all 16-bit x: q = (x * 83056) >> 23.
	localparam logic [16:0] MOD_RECIP = 17'd83056;
	localparam int          MOD_SHIFT = 23;

	localparam logic OP_PATTERN = 1'b0;
	localparam logic OP_TEXT    = 1'b1;

	localparam logic [1:0] ROLL_FIRST = 2'd0;
	localparam logic [1:0] ROLL_LAST  = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LEAVE,
		ST_ROLL,
		ST_SCAN,
		ST_TAIL,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic accept;
		logic pat_write;
		logic text_clear;
		logic scan_init;
		logic scan_step;
		logic win_write;
		logic wh_roll;
		logic commit_hash;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic pat_room;
		logic scan_last;
		logic out_free;
	} sts_t;

	function automatic logic [HASH_W-1:0] mod101(input logic [15:0] x);
		logic [32:0] prod;
		logic [9:0]  quo;
		logic [15:0] rem;
		prod = 33'(x) * 33'(MOD_RECIP);
		quo  = prod[MOD_SHIFT +: 10];
		rem  = x - 16'(quo) * 16'(HASH_MOD);
		return rem[HASH_W-1:0];
	endfunction

endpackage

[design/rolling_hash_substring_search.sv]
// Top level of the Rabin-Karp substring search block: controller plus datapath.
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------------
//  in       | in_valid / in_ready | opcode, data_byte, first
//  out      | out_valid/out_ready | match_found, hash_hit, match_position
//  cfg      | cfg_wr_en           | cfg_wr_data (pattern_length)
//
// From acceptance to the next ready, a text request (len = effective pattern length) goes
// through a window read for the leaving byte, the rolling hash arithmetic, then a scan of
// len bytes through the single read port of each store.
// A stored pattern byte or a length write runs only the scan, which rebuilds
// the pattern hash, window hash and leading power.
// Reset clears the window valid bits at once; no clearing pass. The pattern store is
// undefined until written. A result held by a stalled output stalls only the next text
// request in its finishing state; new requests are still accepted meanwhile.
module rolling_hash_substring_search (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                opcode,
	input  logic [rhss_pkg::BYTE_W-1:0]         data_byte,
	input  logic                                first,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                match_found,
	output logic                                hash_hit,
	output logic [rhss_pkg::POS_W-1:0]          match_position,
	input  logic                                cfg_wr_en,
	input  logic [rhss_pkg::CFG_W-1:0]          cfg_wr_data
);

	rhss_pkg::cmd_t cmd;
	rhss_pkg::sts_t sts;

	// sequencer: owns the handshake on the request side and the job order
	rhss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.opcode    (opcode),
		.first     (first),
		.cfg_wr_en (cfg_wr_en),
		.sts       (sts),
		.in_ready  (in_ready),
		.cmd       (cmd)
	);

	// stores, hashes, scan and the result register
	rhss_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.data_byte      (data_byte),
		.first          (first),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.out_ready      (out_ready),
		.sts            (sts),
		.out_valid      (out_valid),
		.match_found    (match_found),
		.hash_hit       (hash_hit),
		.match_position (match_position)
	);

endmodule

[design/rhss_ctrl.sv]
// Sequencer for the substring search: accepts requests and steps the datapath through each job.
module rhss_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           opcode,
	input  logic           first,
	input  logic           cfg_wr_en,
	input  rhss_pkg::sts_t sts,
	output logic           in_ready,
	output rhss_pkg::cmd_t cmd
);

	rhss_pkg::state_t state_q, state_d;
	logic             text_q, text_d;
	logic [1:0]       roll_q, roll_d;
	logic             pend_q, pend_clr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rhss_pkg::ST_IDLE;
			text_q  <= 1'b0;
			roll_q  <= rhss_pkg::ROLL_FIRST;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			text_q  <= text_d;
			roll_q  <= roll_d;
			// a length write always wins over a clear in the same cycle
			if (cfg_wr_en) begin
				pend_q <= 1'b1;
			end else if (pend_clr) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		text_d   = text_q;
		roll_d   = roll_q;
		pend_clr = 1'b0;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			rhss_pkg::ST_IDLE: begin
				in_ready = !pend_q;
				if (pend_q) begin
					cmd.scan_init = 1'b1;
					pend_clr      = 1'b1;
					text_d        = 1'b0;
					state_d       = rhss_pkg::ST_SCAN;
				end else if (in_valid) begin
					cmd.accept = 1'b1;
					if (opcode == rhss_pkg::OP_TEXT) begin
						cmd.text_clear = first;
						cmd.scan_init  = 1'b1;
						text_d         = 1'b1;
						state_d        = rhss_pkg::ST_LEAVE;
					end else if (first || sts.pat_room) begin
						cmd.pat_write = 1'b1;
						cmd.scan_init = 1'b1;
						text_d        = 1'b0;
						state_d       = rhss_pkg::ST_SCAN;
					end
				end
			end
			rhss_pkg::ST_LEAVE: begin
				roll_d  = rhss_pkg::ROLL_FIRST;
				state_d = rhss_pkg::ST_ROLL;
			end
			rhss_pkg::ST_ROLL: begin
				roll_d = roll_q + 2'd1;
				if (roll_q == rhss_pkg::ROLL_FIRST) begin
					cmd.win_write = 1'b1;
				end
				if (roll_q == rhss_pkg::ROLL_LAST) begin
					cmd.wh_roll   = 1'b1;
					cmd.scan_init = 1'b1;
					state_d       = rhss_pkg::ST_SCAN;
				end
			end
			rhss_pkg::ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					state_d = rhss_pkg::ST_TAIL;
				end
			end
			rhss_pkg::ST_TAIL: begin
				state_d = rhss_pkg::ST_FINISH;
			end
			rhss_pkg::ST_FINISH: begin
				if (!text_q) begin
					cmd.commit_hash = 1'b1;
					state_d         = rhss_pkg::ST_IDLE;
				end else if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = rhss_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rhss_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[design/rhss_dp.sv]
// Datapath: pattern store, circular text window, hash registers, scan unit and result register.
module rhss_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rhss_pkg::cmd_t                      cmd,
	input  logic [rhss_pkg::BYTE_W-1:0]         data_byte,
	input  logic                                first,
	input  logic                                cfg_wr_en,
	input  logic [rhss_pkg::CFG_W-1:0]          cfg_wr_data,
	input  logic                                out_ready,
	output rhss_pkg::sts_t                      sts,
	output logic                                out_valid,
	output logic                                match_found,
	output logic                                hash_hit,
	output logic [rhss_pkg::POS_W-1:0]          match_position
);

	localparam int N  = rhss_pkg::MAX_PATTERN;
	localparam int IW = rhss_pkg::IDX_W;
	localparam int LW = rhss_pkg::LEN_W;
	localparam int HW = rhss_pkg::HASH_W;
	localparam int BW = rhss_pkg::BYTE_W;
	localparam int PW = rhss_pkg::POS_W;

	logic [BW-1:0] pat_mem [N];
	logic [BW-1:0] win_mem [N];

	logic [rhss_pkg::CFG_W-1:0] cfg_q;
	logic [LW-1:0]              len, len_m1;
	logic [BW-1:0]              byte_q;
	logic [LW-1:0]              fill_q;
	logic [IW-1:0]              wp_q;
	logic [N-1:0]               win_vld_q;
	logic [HW-1:0]              ph_q, wh_q, lp_q;
	logic [PW-1:0]              tc_q;

	logic [IW-1:0] pat_idx_q, win_ptr_q, scan_base, pat_waddr;
	logic [LW:0]   base_sum;
	logic [BW-1:0] pat_rd_q, win_raw_q, win_byte;
	logic          win_vld_rd_q;
	logic          step_s1, head_s1;
	logic          eq_acc_q;
	logic [HW-1:0] ph_acc_q, wh_acc_q, lp_acc_q;

	logic [14:0]   prod_s1;
	logic [HW-1:0] rem_s2;
	logic [14:0]   roll_s3;
	logic [7:0]    diff, diff_red;

	logic          full;
	logic          out_valid_q, match_q, hit_q;
	logic [PW-1:0] pos_q;

	// effective length: zero acts as one, clamp at the store depth
	always_comb begin
		if (cfg_q == '0) begin
			len = LW'(1);
		end else if (32'(cfg_q) > N) begin
			len = LW'(N);
		end else begin
			len = LW'(cfg_q);
		end
		len_m1 = len - LW'(1);
	end

	// oldest window byte sits len places behind the write pointer
	always_comb begin
		base_sum = (LW+1)'(wp_q) + (LW+1)'(N) - (LW+1)'(len);
		if (base_sum >= (LW+1)'(N)) begin
			scan_base = IW'(base_sum - (LW+1)'(N));
		end else begin
			scan_base = IW'(base_sum);
		end
	end

	assign pat_waddr = first ? '0 : fill_q[IW-1:0];
	assign win_byte  = win_vld_rd_q ? win_raw_q : '0;

	assign full = tc_q >= PW'(len);

	// (wh - leaving * lp) mod 101, kept in 1..201 before the one correction
	always_comb begin
		diff     = 8'(wh_q) + 8'(rhss_pkg::HASH_MOD) - 8'(rem_s2);
		diff_red = (diff >= 8'(rhss_pkg::HASH_MOD)) ? diff - 8'(rhss_pkg::HASH_MOD) : diff;
	end

	always_ff @(posedge clk) begin
		if (cmd.pat_write) begin
			pat_mem[pat_waddr] <= data_byte;
		end
		pat_rd_q <= pat_mem[pat_idx_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.win_write) begin
			win_mem[wp_q] <= byte_q;
		end
		win_raw_q <= win_mem[win_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q       <= rhss_pkg::CFG_W'(1);
			fill_q      <= '0;
			wp_q        <= '0;
			win_vld_q   <= '0;
			ph_q        <= '0;
			wh_q        <= '0;
			lp_q        <= HW'(1);
			tc_q        <= '0;
			step_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			step_s1 <= cmd.scan_step;
			if (cfg_wr_en) begin
				cfg_q <= cfg_wr_data;
			end
			if (cmd.pat_write) begin
				fill_q <= (first ? '0 : fill_q) + LW'(1);
			end
			if (cmd.text_clear) begin
				win_vld_q <= '0;
				tc_q      <= '0;
				wh_q      <= '0;
			end
			if (cmd.win_write) begin
				win_vld_q[wp_q] <= 1'b1;
				wp_q            <= (wp_q == IW'(N - 1)) ? '0 : wp_q + IW'(1);
				if (tc_q != '1) begin
					tc_q <= tc_q + PW'(1);
				end
			end
			if (cmd.wh_roll) begin
				wh_q <= rhss_pkg::mod101(16'(roll_s3));
			end
			if (cmd.commit_hash) begin
				ph_q <= ph_acc_q;
				wh_q <= wh_acc_q;
				lp_q <= lp_acc_q;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		win_vld_rd_q <= win_vld_q[win_ptr_q];
		head_s1      <= (pat_idx_q == '0);

		if (cmd.accept) begin
			byte_q <= data_byte;
		end

		if (cmd.scan_init) begin
			pat_idx_q <= '0;
			win_ptr_q <= scan_base;
		end else if (cmd.scan_step) begin
			pat_idx_q <= pat_idx_q + IW'(1);
			win_ptr_q <= (win_ptr_q == IW'(N - 1)) ? '0 : win_ptr_q + IW'(1);
		end

		// one pattern byte and one window byte a cycle, oldest first
		if (cmd.scan_init) begin
			eq_acc_q <= 1'b1;
			ph_acc_q <= '0;
			wh_acc_q <= '0;
			lp_acc_q <= HW'(1);
		end else if (step_s1) begin
			eq_acc_q <= eq_acc_q & (win_byte == pat_rd_q);
			ph_acc_q <= rhss_pkg::mod101({1'b0, ph_acc_q, pat_rd_q});
			wh_acc_q <= rhss_pkg::mod101({1'b0, wh_acc_q, win_byte});
			if (!head_s1) begin
				lp_acc_q <= rhss_pkg::mod101({1'b0, lp_acc_q, 8'h00});
			end
		end

		// rolling update: multiply, reduce, subtract and shift in, reduce
		prod_s1 <= 15'(win_byte) * 15'(lp_q);
		rem_s2  <= rhss_pkg::mod101(16'(prod_s1));
		roll_s3 <= {diff_red[HW-1:0], byte_q};

		if (cmd.load_out) begin
			match_q <= full & eq_acc_q;
			hit_q   <= full & (wh_q == ph_q);
			pos_q   <= full ? tc_q - PW'(len) : '0;
		end
	end

	assign sts.pat_room  = fill_q < LW'(N);
	assign sts.scan_last = (LW'(pat_idx_q) == len_m1);
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid      = out_valid_q;
	assign match_found    = match_q;
	assign hash_hit       = hit_q;
	assign match_position = pos_q;

endmodule

[design/rhss_checker.sv]
// Port-level checks for the rolling hash substring search block, bound to its top level.
module rhss_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                opcode,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic                                match_found,
	input logic                                hash_hit,
	input logic [rhss_pkg::POS_W-1:0]          match_position,
	input logic                                cfg_wr_en
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(match_found) &&
			$stable(hash_hit) && $stable(match_position))
		else $error("result changed while stalled");

	// equal bytes give equal hashes
	a_match_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && match_found |-> hash_hit)
		else $error("byte match without hash hit");

	// a text request keeps the block busy after its acceptance
	a_text_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && opcode == rhss_pkg::OP_TEXT |=> !in_ready)
		else $error("ready straight after a text request");

	// a length write forces a rebuild before the next request
	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |=> !in_ready)
		else $error("ready straight after a length write");

	// a fresh result only appears from the finishing step, never from idle
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result raised while idle");

endmodule

bind rolling_hash_substring_search rhss_checker u_rhss_checker (.*);

[tb/rolling_hash_substring_search_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the rolling hash substring search block: directed and random requests.
module rolling_hash_substring_search_tb;

	localparam int HASH_BASE     = 256;
	localparam int ITEM_TARGET   = 1050;
	// Longest internal pass (full-length scan plus the hash pipeline) with margin.
	localparam int SETTLE_CYCLES = rhss_pkg::MAX_PATTERN + 12;

	typedef struct packed {
		logic                       match_found;
		logic                       hash_hit;
		logic [rhss_pkg::POS_W-1:0] position;
	} search_result_t;

	logic                        clk         = 1'b0;
	logic                        arst_n      = 1'b0;
	logic                        in_valid    = 1'b0;
	logic                        in_ready;
	logic                        opcode      = rhss_pkg::OP_PATTERN;
	logic [rhss_pkg::BYTE_W-1:0] data_byte   = '0;
	logic                        first       = 1'b0;
	logic                        out_valid;
	logic                        out_ready   = 1'b0;
	logic                        match_found;
	logic                        hash_hit;
	logic [rhss_pkg::POS_W-1:0]  match_position;
	logic                        cfg_wr_en   = 1'b0;
	logic [rhss_pkg::CFG_W-1:0]  cfg_wr_data = '0;

	rolling_hash_substring_search dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.opcode         (opcode),
		.data_byte      (data_byte),
		.first          (first),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.match_found    (match_found),
		.hash_hit       (hash_hit),
		.match_position (match_position),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Search predictor: own copy of pattern store, window and hashes
	// ------------------------------------------------------------------
	logic [rhss_pkg::BYTE_W-1:0] pat_store [rhss_pkg::MAX_PATTERN];
	logic [rhss_pkg::BYTE_W-1:0] win_store [rhss_pkg::MAX_PATTERN];  // entry 0 = newest byte
	int unsigned                 pat_hash;
	int unsigned                 win_hash;
	int unsigned                 lead_pow;                  // 256^(len-1) mod 101
	int unsigned                 pat_fill;
	int unsigned                 len_reg;
	logic [rhss_pkg::POS_W-1:0]  text_count;

	search_result_t    pending_results [$];
	int unsigned       error_count = 0;
	int unsigned       items_sent  = 0;
	bit                idle_on     = 1'b1;
	int unsigned       stall_left  = 0;

	// Register value clamped into 1..MAX_PATTERN.
	function automatic int unsigned active_length();
		if (len_reg == 0)
			return 1;
		if (len_reg > rhss_pkg::MAX_PATTERN)
			return rhss_pkg::MAX_PATTERN;
		return len_reg;
	endfunction

	// Rebuild both hashes and the leading power for the current length.
	function automatic void rehash();
		int unsigned n;
		int unsigned i;
		n = active_length();
		lead_pow = 1;
		for (i = 1; i < n; i++)
			lead_pow = (lead_pow * HASH_BASE) % rhss_pkg::HASH_MOD;
		pat_hash = 0;
		win_hash = 0;
		for (i = 0; i < n; i++) begin
			pat_hash = (pat_hash * HASH_BASE + pat_store[i]) % rhss_pkg::HASH_MOD;
			// oldest window byte goes in first
			win_hash = (win_hash * HASH_BASE + win_store[n - 1 - i]) % rhss_pkg::HASH_MOD;
		end
	endfunction

	function automatic void search_reset();
		int unsigned i;
		for (i = 0; i < rhss_pkg::MAX_PATTERN; i++) begin
			pat_store[i] = '0;
			win_store[i] = '0;
		end
		pat_fill   = 0;
		text_count = '0;
		len_reg    = 1;
		rehash();
	endfunction

	// Apply one accepted request; a text byte queues its expected result.
	function automatic void predict_search(input logic op,
			input logic [rhss_pkg::BYTE_W-1:0] b, input logic restart);
		int unsigned    n;
		int unsigned    i;
		int unsigned    leaving;
		int unsigned    rolled;
		bit             equal;
		bit             full;
		search_result_t res;
		n = active_length();
		if (op == rhss_pkg::OP_PATTERN) begin
			if (restart)
				pat_fill = 0;
			// bytes beyond the store depth are dropped
			if (pat_fill < rhss_pkg::MAX_PATTERN) begin
				pat_store[pat_fill] = b;
				pat_fill++;
				rehash();
			end
			return;
		end
		if (restart) begin
			for (i = 0; i < rhss_pkg::MAX_PATTERN; i++)
				win_store[i] = '0;
			win_hash   = 0;
			text_count = '0;
		end
		// roll: remove the leaving byte's weight, shift in the new byte
		leaving  = win_store[n - 1];
		rolled   = (win_hash + rhss_pkg::HASH_MOD - (leaving * lead_pow) % rhss_pkg::HASH_MOD)
			% rhss_pkg::HASH_MOD;
		win_hash = (rolled * HASH_BASE + b) % rhss_pkg::HASH_MOD;
		for (i = rhss_pkg::MAX_PATTERN - 1; i > 0; i--)
			win_store[i] = win_store[i - 1];
		win_store[0] = b;
		if (text_count != '1)
			text_count++;
		full  = (text_count >= n);
		equal = 1'b1;
		for (i = 0; i < n; i++)
			if (win_store[n - 1 - i] != pat_store[i])
				equal = 1'b0;
		res.match_found = full && equal;
		res.hash_hit    = full && (win_hash == pat_hash);
		res.position    = full ? text_count - n : '0;
		pending_results.push_back(res);
	endfunction

	// ------------------------------------------------------------------
	// Output side: random back-pressure and result checking
	// ------------------------------------------------------------------
	// out_ready drops in random bursts while idling is enabled.
	always @(posedge clk) begin
		if (!idle_on) begin
			stall_left <= 0;
			out_ready  <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= (stall_left == 1);
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(1, 5);
			out_ready  <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	function automatic void check_field(input string name,
			input logic [rhss_pkg::POS_W-1:0] want, input logic [rhss_pkg::POS_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin
		search_result_t want;
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with none expected, actual match %0b hit %0b pos %0d",
					$time, match_found, hash_hit, match_position);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("match_found", rhss_pkg::POS_W'(want.match_found),
					rhss_pkg::POS_W'(match_found));
				check_field("hash_hit", rhss_pkg::POS_W'(want.hash_hit),
					rhss_pkg::POS_W'(hash_hit));
				check_field("match_position", want.position, match_position);
			end
		end
	end

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------
	// Valid is left high after acceptance so back-to-back requests need no
	// second assignment in the same step; a gap or a pause lowers it.
	task automatic send_request(input logic op, input logic [rhss_pkg::BYTE_W-1:0] b,
			input logic restart);
		int unsigned gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		opcode    <= op;
		data_byte <= b;
		first     <= restart;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		// overflowing pattern bytes are ignored by the block and not counted
		if (op == rhss_pkg::OP_TEXT || restart || pat_fill < rhss_pkg::MAX_PATTERN)
			items_sent++;
		predict_search(op, b, restart);
	endtask

	// Length writes only once the block has drained and finished any scan.
	task automatic write_length(input logic [rhss_pkg::CFG_W-1:0] value);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		len_reg = value;
		rehash();
	endtask

	// Bias towards a small alphabet so that windows actually repeat.
	function automatic logic [rhss_pkg::BYTE_W-1:0] pick_byte(
			input logic [rhss_pkg::BYTE_W-1:0] alpha);
		if ($urandom_range(0, 9) < 6)
			return alpha + rhss_pkg::BYTE_W'($urandom_range(0, 2));
		return rhss_pkg::BYTE_W'($urandom_range(0, 255));
	endfunction

	task automatic load_pattern(input int unsigned count,
			input logic [rhss_pkg::BYTE_W-1:0] alpha);
		int unsigned j;
		for (j = 0; j < count; j++)
			send_request(rhss_pkg::OP_PATTERN, pick_byte(alpha), j == 0);
	endtask

	// Text stream with embedded copies of the pattern, the odd restart and
	// the odd pattern byte slipped in mid-text.
	task automatic stream_text(input int unsigned count, input logic restart_first,
			input logic [rhss_pkg::BYTE_W-1:0] alpha);
		int unsigned k;
		int unsigned j;
		int unsigned n;
		k = 0;
		while (k < count) begin
			n = active_length();
			if ($urandom_range(0, 99) < 3) begin
				send_request(rhss_pkg::OP_PATTERN,
					rhss_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0);
			end else if ($urandom_range(0, 99) < 12) begin
				for (j = 0; j < n; j++)
					send_request(rhss_pkg::OP_TEXT, pat_store[j],
						restart_first && k == 0 && j == 0);
				k += n;
			end else begin
				send_request(rhss_pkg::OP_TEXT, pick_byte(alpha),
					(restart_first && k == 0) || $urandom_range(0, 49) == 0);
				k++;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// Reset length of one: only store entry 0 is searched for.
	task automatic test_reset_length();
		send_request(rhss_pkg::OP_PATTERN, 8'h00, 1'b1);
		send_request(rhss_pkg::OP_PATTERN, 8'hFF, 1'b0);
		send_request(rhss_pkg::OP_PATTERN, 8'h41, 1'b0);
		send_request(rhss_pkg::OP_TEXT, 8'h00, 1'b1);
		send_request(rhss_pkg::OP_TEXT, 8'hFF, 1'b0);
		send_request(rhss_pkg::OP_TEXT, 8'h00, 1'b0);
	endtask

	// Zero length acts as one; length changes mid-text rehash the live window.
	task automatic test_length_limits();
		write_length('0);
		send_request(rhss_pkg::OP_TEXT, 8'hFF, 1'b1);
		write_length(7'd3);
		send_request(rhss_pkg::OP_TEXT, 8'h00, 1'b0);
		send_request(rhss_pkg::OP_TEXT, 8'hFF, 1'b0);
		send_request(rhss_pkg::OP_TEXT, 8'h41, 1'b0);
		send_request(rhss_pkg::OP_TEXT, 8'h00, 1'b0);
		send_request(rhss_pkg::OP_TEXT, 8'hFF, 1'b0);
		send_request(rhss_pkg::OP_TEXT, 8'h41, 1'b0);
		write_length(7'd2);
		send_request(rhss_pkg::OP_TEXT, 8'h00, 1'b0);
		send_request(rhss_pkg::OP_TEXT, 8'hFF, 1'b0);
	endtask

	// Short reload: the third byte of the old pattern still takes part.
	task automatic test_partial_pattern();
		write_length(7'd3);
		send_request(rhss_pkg::OP_PATTERN, 8'hAA, 1'b1);
		send_request(rhss_pkg::OP_PATTERN, 8'h55, 1'b0);
		send_request(rhss_pkg::OP_TEXT, 8'hAA, 1'b1);
		send_request(rhss_pkg::OP_TEXT, 8'h55, 1'b0);
		send_request(rhss_pkg::OP_TEXT, 8'h41, 1'b0);
	endtask

	// Fill the whole store plus overflow, then search at the clamped maximum.
	task automatic test_full_store();
		logic [rhss_pkg::BYTE_W-1:0] alpha;
		int unsigned                 j;
		alpha = rhss_pkg::BYTE_W'($urandom_range(0, 255));
		load_pattern(rhss_pkg::MAX_PATTERN + 3, alpha);
		write_length(7'd127);
		for (j = 0; j < 3; j++)
			send_request(rhss_pkg::OP_TEXT, pick_byte(alpha), j == 0);
		for (j = 0; j < rhss_pkg::MAX_PATTERN; j++)
			send_request(rhss_pkg::OP_TEXT, pat_store[j], 1'b0);
		write_length(rhss_pkg::CFG_W'(rhss_pkg::MAX_PATTERN));
		stream_text(20, 1'b0, alpha);
	endtask

	// Random phases: length, pattern load and a text stream each. Mostly
	// short patterns; some phases keep the previous window.
	task automatic test_random_search();
		logic [rhss_pkg::BYTE_W-1:0] alpha;
		int unsigned                 pick;
		int unsigned                 n;
		int unsigned                 count;
		bit                          carry_on;
		carry_on = 1'b0;
		while (items_sent < ITEM_TARGET - 60) begin
			idle_on = ($urandom_range(0, 4) != 0);
			alpha   = rhss_pkg::BYTE_W'($urandom_range(0, 255));
			pick    = $urandom_range(0, 19);
			if (pick < 14)
				write_length(rhss_pkg::CFG_W'($urandom_range(1, 6)));
			else if (pick < 17)
				write_length(rhss_pkg::CFG_W'($urandom_range(7, 16)));
			else if (pick == 17)
				write_length('0);
			else if (pick == 18)
				write_length(rhss_pkg::CFG_W'(rhss_pkg::MAX_PATTERN));
			else
				write_length(rhss_pkg::CFG_W'($urandom_range(rhss_pkg::MAX_PATTERN + 1,
					127)));
			n    = active_length();
			pick = $urandom_range(0, 19);
			if (pick < 15)
				count = n;
			else if (pick < 18)
				count = $urandom_range(1, n);
			else
				count = n + $urandom_range(1, 4);
			load_pattern(count, alpha);
			count = (n > 16) ? n + $urandom_range(4, 16) : $urandom_range(12, 40);
			stream_text(count, !carry_on, alpha);
			carry_on = ($urandom_range(0, 3) == 0);
		end
	endtask

	// Closing stretch at full rate on both sides.
	task automatic test_steady_stream();
		logic [rhss_pkg::BYTE_W-1:0] alpha;
		idle_on = 1'b0;
		alpha   = rhss_pkg::BYTE_W'($urandom_range(0, 255));
		write_length(7'd4);
		load_pattern(4, alpha);
		stream_text(50, 1'b1, alpha);
	endtask

	initial begin
		search_reset();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_length();
		test_length_limits();
		test_partial_pattern();
		test_full_store();
		test_random_search();
		test_steady_stream();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		// let any stray result surface
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("rolling_hash_substring_search_tb: PASS");
		else
			$display("rolling_hash_substring_search_tb: FAIL");
		$finish;
	end

	// Watchdog: several times the slowest legal run.
	initial begin
		#3000000;
		$display("rolling_hash_substring_search_tb: FAIL");
		$finish;
	end

endmodule

[sim.f]
design/rhss_pkg.sv
design/rhss_ctrl.sv
design/rhss_dp.sv
design/rolling_hash_substring_search.sv
design/rhss_checker.sv
tb/rolling_hash_substring_search_tb.sv
